FILE: hdl/pmftl_pkg.sv
// ----------------------------------------------------------------------------
// pmftl_pkg: shared types and constants of the page-mapping FTL
// Geometry, command and status codes, and the output beat record.
// ----------------------------------------------------------------------------
`default_nettype none
package pmftl_pkg;
  localparam int unsigned BLOCKS          = 64;
  localparam int unsigned PAGES_PER_BLOCK = 32;
  localparam int unsigned USER_BLOCKS     = 56;
  localparam int unsigned LOG_PAGES       = USER_BLOCKS * PAGES_PER_BLOCK;
  localparam int unsigned PHYS_PAGES      = BLOCKS * PAGES_PER_BLOCK;
  localparam int unsigned BW  = 6;
  localparam int unsigned PW  = 5;
  localparam int unsigned LW  = 11;
  localparam int unsigned PPW = BW + PW;

  localparam logic [2:0] CMD_READ  = 3'd0;
  localparam logic [2:0] CMD_PROG  = 3'd1;
  localparam logic [2:0] CMD_COPY  = 3'd2;
  localparam logic [2:0] CMD_ERASE = 3'd3;
  localparam logic [2:0] CMD_ERR   = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNMAP   = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;
  localparam logic [1:0] ST_NORECL  = 2'd3;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [BW-1:0] dst_block;
    logic [PW-1:0] dst_page;
    logic [BW-1:0] src_block;
    logic [PW-1:0] src_page;
    logic [LW-1:0] tag_lpn;
    logic [31:0] data;
    logic [1:0]  status;
    logic        last;
  } beat_t;
endpackage
`default_nettype wire

FILE: hdl/pmftl_ram.sv
// ----------------------------------------------------------------------------
// pmftl_ram: generic single-port-write, one-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module pmftl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

FILE: hdl/pmftl_outq.sv
// ----------------------------------------------------------------------------
// pmftl_outq: output register stage
// Holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none
module pmftl_outq import pmftl_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  beat_t      beat_i,
  output logic       full_o,
  input  wire logic  stall_i,
  output logic       valid_o,
  output beat_t      beat_o
);
  logic v_q;
  beat_t b_q;
  assign full_o  = v_q && stall_i;
  assign valid_o = v_q;
  assign beat_o  = b_q;
  // load on push, clear when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (push_i) begin
      v_q <= 1'b1;
    end else if (!stall_i) begin
      v_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (push_i) b_q <= beat_i;
  end
endmodule
`default_nettype wire

FILE: hdl/page_map_ftl_greedy_gc_top.sv
// ----------------------------------------------------------------------------
// page_map_ftl_greedy_gc_top: page-mapping FTL with greedy collection
// Sequencer over mapping RAMs and block tables, one shared compare unit.
// ----------------------------------------------------------------------------
//  channel | signals                                  | direction
//  in      | in_valid_i/in_stall_o, func/lpn/write_data| sink
//  out     | out_valid_o/out_stall_i, cmd..last        | source
//  Reset clears the logical map, page-invalid bits and block tables in a
//  sweep; no input then.
//  A read holds the block through RD1 and RD2. A write makes two
//  block-table scans (shared compare unit, one block per cycle behind a
//  registered read) plus lookup and program.
//  Collection adds a third scan, the GCP, GCW and GCM states per page, and erase.
//  Output stalls hold the sequencer at each beat.
// ----------------------------------------------------------------------------
`default_nettype none
module page_map_ftl_greedy_gc_top import pmftl_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        func_i,
  input  wire logic [10:0] lpn_i,
  input  wire logic [31:0] write_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       cmd_o,
  output logic [5:0]       dst_block_o,
  output logic [4:0]       dst_page_o,
  output logic [5:0]       src_block_o,
  output logic [4:0]       src_page_o,
  output logic [10:0]      tag_lpn_o,
  output logic [31:0]      data_o,
  output logic [1:0]       status_o,
  output logic             last_o
);
  localparam int unsigned LAW = $clog2(LOG_PAGES);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_RD1, S_RD2, S_ROOM, S_VICT, S_GCP, S_GCW, S_GCR,
    S_GCM, S_ERASE, S_INV1, S_INV2, S_INV3, S_FIND, S_PROG, S_ERR
  } state_e;

  state_e st_q;
  logic [PPW-1:0] clr_q;
  logic [LW-1:0]  lpn_q;
  logic [31:0]    wd_q;
  logic [BW-1:0]  b_q, bd_q, spare_q, victim_q, blk_q;
  logic           bv_q;
  logic [5:0]     best_q;
  logic           room_q, found_q;
  logic [PW-1:0]  pg_q, bpg_q;
  logic [PW:0]    dst_q;
  logic [1:0]     err_q;

  // logical map: bit 11 = mapped
  logic           l2p_we;
  logic [LAW-1:0] l2p_wa, l2p_ra;
  logic [PPW:0]   l2p_wd, l2p_rd;
  pmftl_ram #(.WIDTH(PPW+1), .DEPTH(LOG_PAGES)) u_l2p (
    .clk_i, .we_i(l2p_we), .waddr_i(l2p_wa), .wdata_i(l2p_wd),
    .raddr_i(l2p_ra), .rdata_o(l2p_rd));
  logic           p2l_we;
  logic [PPW-1:0] p2l_wa, p2l_ra;
  logic [LW-1:0]  p2l_wd, p2l_rd;
  pmftl_ram #(.WIDTH(LW), .DEPTH(PHYS_PAGES)) u_p2l (
    .clk_i, .we_i(p2l_we), .waddr_i(p2l_wa), .wdata_i(p2l_wd),
    .raddr_i(p2l_ra), .rdata_o(p2l_rd));
  // page-invalid bits
  logic           inv_we;
  logic [PPW-1:0] inv_wa, inv_ra;
  logic [0:0]     inv_wd, inv_rd;
  pmftl_ram #(.WIDTH(1), .DEPTH(PHYS_PAGES)) u_inv (
    .clk_i, .we_i(inv_we), .waddr_i(inv_wa), .wdata_i(inv_wd),
    .raddr_i(inv_ra), .rdata_o(inv_rd));
  // block tables: pages written and invalid count
  logic           pw_we, ic_we;
  logic [BW-1:0]  pw_wa, pw_ra, ic_wa, ic_ra;
  logic [5:0]     pw_wd, pw_rd, ic_wd, ic_rd;
  pmftl_ram #(.WIDTH(6), .DEPTH(BLOCKS)) u_pw (
    .clk_i, .we_i(pw_we), .waddr_i(pw_wa), .wdata_i(pw_wd),
    .raddr_i(pw_ra), .rdata_o(pw_rd));
  pmftl_ram #(.WIDTH(6), .DEPTH(BLOCKS)) u_ic (
    .clk_i, .we_i(ic_we), .waddr_i(ic_wa), .wdata_i(ic_wd),
    .raddr_i(ic_ra), .rdata_o(ic_rd));

  logic  push, full;
  beat_t beat;
  beat_t ob;
  pmftl_outq u_oq (.clk_i, .rst_ni, .push_i(push), .beat_i(beat), .full_o(full),
    .stall_i(out_stall_i), .valid_o(out_valid_o), .beat_o(ob));
  assign cmd_o = ob.cmd; assign dst_block_o = ob.dst_block;
  assign dst_page_o = ob.dst_page; assign src_block_o = ob.src_block;
  assign src_page_o = ob.src_page; assign tag_lpn_o = ob.tag_lpn;
  assign data_o = ob.data; assign status_o = ob.status; assign last_o = ob.last;

  assign in_stall_o = (st_q != S_IDLE);
  wire acc = in_valid_i && (st_q == S_IDLE);

  // shared compare unit: block bd_q (table data of the previous cycle)
  wire        b_ns   = bv_q && (bd_q != spare_q);
  wire        b_free = b_ns && (pw_rd < 6'(PAGES_PER_BLOCK));
  wire        b_best = b_ns && (ic_rd > best_q);
  wire        b_end  = bv_q && (bd_q == BW'(BLOCKS-1));
  wire        inv_hit = inv_rd[0];
  wire [PPW-1:0] src_pp = {victim_q, pg_q};
  wire [PPW-1:0] spr_pp = {spare_q, dst_q[PW-1:0]};
  wire [PPW-1:0] old_pp = l2p_rd[PPW-1:0];
  wire [PPW-1:0] new_pp = {blk_q, bpg_q};

  // RAM ports
  always_comb begin
    l2p_we = 1'b0; l2p_wa = lpn_q[LAW-1:0]; l2p_wd = '0;
    l2p_ra = lpn_q[LAW-1:0];
    p2l_we = 1'b0; p2l_wa = new_pp; p2l_wd = lpn_q; p2l_ra = src_pp;
    inv_we = 1'b0; inv_wa = new_pp; inv_wd = 1'b0; inv_ra = src_pp;
    pw_we = 1'b0; pw_wa = blk_q; pw_wd = '0; pw_ra = b_q;
    ic_we = 1'b0; ic_wa = victim_q; ic_wd = '0; ic_ra = b_q;
    if (acc) l2p_ra = lpn_i[LAW-1:0];
    unique case (st_q)
      S_CLR: begin
        l2p_we = (clr_q < PPW'(LOG_PAGES)); l2p_wa = clr_q[LAW-1:0];
        inv_we = 1'b1; inv_wa = clr_q;
        pw_we = 1'b1; pw_wa = clr_q[BW-1:0];
        ic_we = 1'b1; ic_wa = clr_q[BW-1:0];
      end
      S_GCM: if (inv_hit) begin
        inv_we = 1'b1; inv_wa = src_pp;
      end else if (!full) begin
        l2p_we = (p2l_rd < LW'(LOG_PAGES));
        l2p_wa = p2l_rd[LAW-1:0];
        l2p_wd = {1'b1, spr_pp};
        p2l_we = 1'b1; p2l_wa = spr_pp; p2l_wd = p2l_rd;
        inv_we = 1'b1; inv_wa = spr_pp;
      end
      S_ERASE: if (!full) begin
        pw_we = 1'b1; pw_wa = spare_q; pw_wd = dst_q;
        ic_we = 1'b1;
      end
      S_GCR: begin
        pw_we = 1'b1; pw_wa = victim_q;
      end
      S_INV2: begin
        inv_ra = old_pp; ic_ra = old_pp[PPW-1:PW];
      end
      S_INV3: begin
        inv_ra = old_pp; ic_ra = old_pp[PPW-1:PW];
        if (l2p_rd[PPW] && !inv_hit) begin
          inv_we = 1'b1; inv_wa = old_pp; inv_wd = 1'b1;
          ic_we = 1'b1; ic_wa = old_pp[PPW-1:PW]; ic_wd = ic_rd + 6'd1;
        end
      end
      S_PROG: if (!full) begin
        l2p_we = 1'b1; l2p_wd = {1'b1, new_pp}; p2l_we = 1'b1;
        inv_we = 1'b1;
        pw_we = 1'b1; pw_wd = {1'b0, bpg_q} + 6'd1;
      end
      default: ;
    endcase
  end

  // output beat
  always_comb begin
    beat = '0; push = 1'b0;
    unique case (st_q)
      S_RD2: begin
        push = !full && l2p_rd[PPW]; beat.cmd = CMD_READ;
        beat.dst_block = l2p_rd[PPW-1:PW]; beat.dst_page = l2p_rd[PW-1:0];
        beat.tag_lpn = lpn_q; beat.last = 1'b1;
      end
      S_ERR: begin
        push = !full; beat.cmd = CMD_ERR; beat.status = err_q; beat.last = 1'b1;
      end
      S_GCM: begin
        push = !full && !inv_hit; beat.cmd = CMD_COPY;
        beat.dst_block = spare_q; beat.dst_page = dst_q[PW-1:0];
        beat.src_block = victim_q; beat.src_page = pg_q; beat.tag_lpn = p2l_rd;
      end
      S_ERASE: begin push = !full; beat.cmd = CMD_ERASE; beat.dst_block = victim_q; end
      S_PROG: begin
        push = !full; beat.cmd = CMD_PROG; beat.dst_block = blk_q;
        beat.dst_page = bpg_q; beat.tag_lpn = lpn_q;
        beat.data = wd_q; beat.last = 1'b1;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLR; clr_q <= '0; spare_q <= BW'(BLOCKS-1);
      lpn_q <= '0; wd_q <= '0; b_q <= '0; bd_q <= '0; bv_q <= 1'b0;
      victim_q <= '0; blk_q <= '0; bpg_q <= '0; best_q <= '0;
      room_q <= 1'b0; found_q <= 1'b0; pg_q <= '0; dst_q <= '0; err_q <= ST_OK;
    end else begin
      unique case (st_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == PPW'(PHYS_PAGES-1)) st_q <= S_IDLE;
        end
        S_IDLE: if (acc) begin
          lpn_q <= lpn_i; wd_q <= write_data_i;
          b_q <= '0; bv_q <= 1'b0; room_q <= 1'b0; best_q <= '0; victim_q <= '0;
          found_q <= 1'b0; blk_q <= '0; bpg_q <= '0;
          if (lpn_i >= LW'(LOG_PAGES)) begin err_q <= ST_RANGE; st_q <= S_ERR; end
          else if (!func_i) st_q <= S_RD1;
          else st_q <= S_ROOM;
        end
        S_RD1: st_q <= S_RD2;
        S_RD2: if (!l2p_rd[PPW]) begin err_q <= ST_UNMAP; st_q <= S_ERR; end
               else if (!full) st_q <= S_IDLE;
        S_ERR: if (!full) st_q <= S_IDLE;
        S_ROOM: begin
          b_q <= b_q + 1'b1; bd_q <= b_q; bv_q <= 1'b1;
          if (b_free) room_q <= 1'b1;
          if (b_end) begin
            b_q <= '0; bv_q <= 1'b0;
            st_q <= (room_q || b_free) ? S_INV1 : S_VICT;
          end
        end
        S_VICT: begin
          b_q <= b_q + 1'b1; bd_q <= b_q; bv_q <= 1'b1;
          if (b_best) begin best_q <= ic_rd; victim_q <= bd_q; end
          if (b_end) begin
            b_q <= '0; bv_q <= 1'b0; pg_q <= '0; dst_q <= '0;
            if (best_q == '0 && !b_best) begin err_q <= ST_NORECL; st_q <= S_ERR; end
            else st_q <= S_GCP;
          end
        end
        S_GCP: st_q <= S_GCW;   // address p2l and invalid bit
        S_GCW: st_q <= S_GCM;   // data arrives
        S_GCM: if (inv_hit || !full) begin
          if (!inv_hit) dst_q <= dst_q + 1'b1;
          pg_q <= pg_q + 1'b1;
          st_q <= (pg_q == PW'(PAGES_PER_BLOCK-1)) ? S_ERASE : S_GCP;
        end
        S_ERASE: if (!full) begin
          spare_q <= victim_q; st_q <= S_GCR;
        end
        S_GCR: st_q <= S_INV1;   // clear fill count of the erased block
        S_INV1: st_q <= S_INV2;
        S_INV2: st_q <= S_INV3;  // old copy address to invalid bits
        S_INV3: begin
          b_q <= '0; bv_q <= 1'b0; st_q <= S_FIND;
        end
        S_FIND: begin
          b_q <= b_q + 1'b1; bd_q <= b_q; bv_q <= 1'b1;
          if (b_free && !found_q) begin
            found_q <= 1'b1; blk_q <= bd_q; bpg_q <= pw_rd[PW-1:0];
          end
          if (b_end) begin bv_q <= 1'b0; st_q <= S_PROG; end
        end
        S_PROG: if (!full) st_q <= S_IDLE;
        default: st_q <= S_IDLE;
      endcase
    end
  end

  // checks
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != S_IDLE) |-> in_stall_o) else $error("input taken while busy");
  a_spare: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && beat.cmd == CMD_PROG) |-> (beat.dst_block != spare_q))
    else $error("program into spare");
  a_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full) else $error("beat overwritten");
endmodule
`default_nettype wire

FILE: tb/sv/page_map_ftl_greedy_gc_top_tb.sv
// ----------------------------------------------------------------------------
// page_map_ftl_greedy_gc_top_tb: regression bench for the greedy-GC page FTL
// Drives read and write beats from a queue, predicts every flash command with
// a behavioral copy of the mapping tables, and checks each output beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module page_map_ftl_greedy_gc_top_tb;
  import pmftl_pkg::*;

  typedef struct packed {
    logic        func;
    logic [10:0] lpn;
    logic [31:0] wdata;
  } host_req_t;

  localparam logic FN_READ  = 1'b0;
  localparam logic FN_WRITE = 1'b1;
  localparam int   CYCLE_LIMIT = 4000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        func_i = 1'b0;
  logic [10:0] lpn_i = '0;
  logic [31:0] write_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  cmd_o;
  logic [5:0]  dst_block_o;
  logic [4:0]  dst_page_o;
  logic [5:0]  src_block_o;
  logic [4:0]  src_page_o;
  logic [10:0] tag_lpn_o;
  logic [31:0] data_o;
  logic [1:0]  status_o;
  logic        last_o;

  page_map_ftl_greedy_gc_top u_dut (.*);

  always #4 clk_i = ~clk_i;

  // Shadow FTL state
  logic [11:0]   l2p_mapped_q [LOG_PAGES];
  logic [10:0]   p2l_tag [PHYS_PAGES];
  logic          pg_stale [PHYS_PAGES];
  int unsigned   blk_fill [BLOCKS];
  int unsigned   blk_stale [BLOCKS];
  bit            l2p_valid [LOG_PAGES];
  int unsigned   spare_blk;

  host_req_t     req_queue[$];
  beat_t         cmd_expected[$];
  int            sender_idle_pct, receiver_idle_pct;
  int            fail_cnt = 0;
  int            cycle_cnt = 0;
  bit            driver_on = 1'b0;

  function automatic beat_t mk_beat(logic [2:0] c, int unsigned db, int unsigned dp,
                                    int unsigned sb, int unsigned sp, int unsigned tag,
                                    logic [31:0] d, logic [1:0] st, logic lst);
    beat_t b;
    b.cmd = c; b.dst_block = BW'(db); b.dst_page = PW'(dp); b.src_block = BW'(sb);
    b.src_page = PW'(sp); b.tag_lpn = LW'(tag); b.data = d; b.status = st;
    b.last = lst;
    return b;
  endfunction

  function automatic void shadow_reset();
    for (int i = 0; i < LOG_PAGES; i++) l2p_valid[i] = 1'b0;
    for (int i = 0; i < PHYS_PAGES; i++) begin
      pg_stale[i] = 1'b0;
      p2l_tag[i] = '0;
    end
    for (int b = 0; b < BLOCKS; b++) begin
      blk_fill[b] = 0;
      blk_stale[b] = 0;
    end
    spare_blk = BLOCKS - 1;
  endfunction

  // Compute flash commands caused by one host request
  function automatic void predict_commands(host_req_t r);
    bit room;
    int unsigned victim, best, sp, dst, src, np, ppn, blk, pg, tag;
    room = 1'b0;
    if (r.lpn >= LOG_PAGES) begin
      cmd_expected.push_back(mk_beat(CMD_ERR, 0, 0, 0, 0, 0, '0, ST_RANGE, 1'b1));
      return;
    end
    if (r.func == FN_READ) begin
      if (!l2p_valid[r.lpn])
        cmd_expected.push_back(mk_beat(CMD_ERR, 0, 0, 0, 0, 0, '0, ST_UNMAP, 1'b1));
      else begin
        ppn = l2p_mapped_q[r.lpn];
        cmd_expected.push_back(mk_beat(CMD_READ, ppn / PAGES_PER_BLOCK,
          ppn % PAGES_PER_BLOCK, 0, 0, r.lpn, '0, ST_OK, 1'b1));
      end
      return;
    end
    for (int b = 0; b < BLOCKS; b++)
      if (b != spare_blk && blk_fill[b] < PAGES_PER_BLOCK) room = 1'b1;
    if (!room) begin
      victim = 0; best = 0; sp = spare_blk; dst = 0;
      for (int b = 0; b < BLOCKS; b++)
        if (b != sp && blk_stale[b] > best) begin
          best = blk_stale[b];
          victim = b;
        end
      if (best == 0) begin
        cmd_expected.push_back(mk_beat(CMD_ERR, 0, 0, 0, 0, 0, '0, ST_NORECL, 1'b1));
        return;
      end
      // Relocate valid pages of the victim into the spare
      for (int i = 0; i < PAGES_PER_BLOCK; i++) begin
        src = victim * PAGES_PER_BLOCK + i;
        if (pg_stale[src]) pg_stale[src] = 1'b0;
        else begin
          tag = p2l_tag[src];
          np = sp * PAGES_PER_BLOCK + dst;
          cmd_expected.push_back(mk_beat(CMD_COPY, sp, dst, victim, i, tag, '0,
                                         ST_OK, 1'b0));
          p2l_tag[np] = LW'(tag);
          pg_stale[np] = 1'b0;
          if (tag < LOG_PAGES) begin
            l2p_valid[tag] = 1'b1;
            l2p_mapped_q[tag] = 12'(np);
          end
          dst++;
        end
      end
      cmd_expected.push_back(mk_beat(CMD_ERASE, victim, 0, 0, 0, 0, '0, ST_OK, 1'b0));
      blk_fill[sp] = dst;
      blk_fill[victim] = 0;
      blk_stale[victim] = 0;
      spare_blk = victim;
    end
    if (l2p_valid[r.lpn]) begin
      ppn = l2p_mapped_q[r.lpn];
      if (!pg_stale[ppn]) begin
        pg_stale[ppn] = 1'b1;
        blk_stale[ppn / PAGES_PER_BLOCK]++;
      end
    end
    blk = 0;
    for (int b = 0; b < BLOCKS; b++)
      if (b != spare_blk && blk_fill[b] < PAGES_PER_BLOCK) begin
        blk = b;
        break;
      end
    pg = blk_fill[blk] % PAGES_PER_BLOCK;
    blk_fill[blk] = pg + 1;
    ppn = blk * PAGES_PER_BLOCK + pg;
    l2p_valid[r.lpn] = 1'b1;
    l2p_mapped_q[r.lpn] = 12'(ppn);
    p2l_tag[ppn] = r.lpn;
    pg_stale[ppn] = 1'b0;
    cmd_expected.push_back(mk_beat(CMD_PROG, blk, pg, 0, 0, r.lpn, r.wdata, ST_OK, 1'b1));
  endfunction

  function automatic host_req_t mk_req(int unsigned f, int unsigned l, logic [31:0] d);
    host_req_t r;
    r.func = 1'(f); r.lpn = LW'(l); r.wdata = d;
    return r;
  endfunction

  // Driver: present queued requests, hold while stalled
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      predict_commands(mk_req(func_i, lpn_i, write_data_i));
      void'(req_queue.pop_front());
    end
    if (in_valid_i && in_stall_o) begin
      // hold the beat
    end else if (driver_on && req_queue.size() > 0 &&
                 (in_valid_i && !in_stall_o ? req_queue.size() > 0 : 1'b1) &&
                 $urandom_range(99) >= sender_idle_pct) begin
      in_valid_i   <= 1'b1;
      func_i       <= req_queue[0].func;
      lpn_i        <= req_queue[0].lpn;
      write_data_i <= req_queue[0].wdata;
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Monitor: check each accepted output beat, randomize backpressure
  always @(posedge clk_i) begin
    beat_t got, want;
    cycle_cnt++;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = mk_beat(cmd_o, dst_block_o, dst_page_o, src_block_o, src_page_o,
                    tag_lpn_o, data_o, status_o, last_o);
      if (cmd_expected.size() == 0) begin
        $display("%0t: unexpected beat %h", $time, got);
        fail_cnt++;
      end else begin
        want = cmd_expected.pop_front();
        if (got.cmd != want.cmd) begin
          $display("%0t: cmd exp %0d got %0d", $time, want.cmd, got.cmd); fail_cnt++;
        end
        if (got.dst_block != want.dst_block) begin
          $display("%0t: dst_block exp %0d got %0d", $time, want.dst_block,
                   got.dst_block); fail_cnt++;
        end
        if (got.dst_page != want.dst_page) begin
          $display("%0t: dst_page exp %0d got %0d", $time, want.dst_page,
                   got.dst_page); fail_cnt++;
        end
        if (got.src_block != want.src_block) begin
          $display("%0t: src_block exp %0d got %0d", $time, want.src_block,
                   got.src_block); fail_cnt++;
        end
        if (got.src_page != want.src_page) begin
          $display("%0t: src_page exp %0d got %0d", $time, want.src_page,
                   got.src_page); fail_cnt++;
        end
        if (got.tag_lpn != want.tag_lpn) begin
          $display("%0t: tag_lpn exp %0d got %0d", $time, want.tag_lpn,
                   got.tag_lpn); fail_cnt++;
        end
        if (got.data != want.data) begin
          $display("%0t: data exp %h got %h", $time, want.data, got.data); fail_cnt++;
        end
        if (got.status != want.status) begin
          $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
          fail_cnt++;
        end
        if (got.last != want.last) begin
          $display("%0t: last exp %0d got %0d", $time, want.last, got.last); fail_cnt++;
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < receiver_idle_pct);
  end

  // Timeout
  always @(posedge clk_i) begin
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("page_map_ftl_greedy_gc_top regression: fail");
      $finish;
    end
  end

  function automatic int unsigned rand_lpn(int unsigned span);
    return $urandom_range(span - 1);
  endfunction

  // Queue a burst and wait for it to drain
  task automatic run_phase(int s_pct, int r_pct, int n, int unsigned span);
    int unsigned k;
    sender_idle_pct = s_pct;
    receiver_idle_pct = r_pct;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 4)
        req_queue.push_back(mk_req($urandom_range(1), LOG_PAGES + $urandom_range(255),
                                   $urandom));
      else if (k < 34)
        req_queue.push_back(mk_req(FN_READ, rand_lpn(span), $urandom));
      else
        req_queue.push_back(mk_req(FN_WRITE, rand_lpn(span), $urandom));
    end
    while (req_queue.size() > 0 || in_valid_i) @(posedge clk_i);
  endtask

  initial begin
    shadow_reset();
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Wait out the table clearing sweep
    repeat (PHYS_PAGES + 64) @(posedge clk_i);
    driver_on = 1'b1;

    // Directed: field extremes, unmapped read, range errors, overwrite
    req_queue.push_back(mk_req(FN_READ, 0, '0));
    req_queue.push_back(mk_req(FN_READ, LOG_PAGES - 1, '0));
    req_queue.push_back(mk_req(FN_READ, 2047, '1));
    req_queue.push_back(mk_req(FN_WRITE, 2047, 32'hFFFF_FFFF));
    req_queue.push_back(mk_req(FN_WRITE, LOG_PAGES, 32'h1234_5678));
    req_queue.push_back(mk_req(FN_WRITE, 0, 32'h0000_0000));
    req_queue.push_back(mk_req(FN_WRITE, LOG_PAGES - 1, 32'hFFFF_FFFF));
    req_queue.push_back(mk_req(FN_WRITE, 1365, 32'hAAAA_AAAA));
    req_queue.push_back(mk_req(FN_WRITE, 682, 32'h5555_5555));
    req_queue.push_back(mk_req(FN_READ, 0, '0));
    req_queue.push_back(mk_req(FN_READ, LOG_PAGES - 1, '0));
    req_queue.push_back(mk_req(FN_WRITE, 0, 32'hDEAD_BEEF));
    req_queue.push_back(mk_req(FN_READ, 0, '0));
    req_queue.push_back(mk_req(FN_READ, 1365, '0));
    run_phase(0, 0, 0, 1);

    // Random phases; a small lpn span forces overwrites
    run_phase(18, 79, 150, 64);
    run_phase(79, 18, 150, 64);
    run_phase(0, 0, 156, 64);
    driver_on = 1'b0;

    // Drain
    while (cmd_expected.size() > 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("page_map_ftl_greedy_gc_top regression: pass");
    end else begin
      $display("page_map_ftl_greedy_gc_top regression: fail");
    end
    $finish;
  end
endmodule

FILE: sim.f
hdl/pmftl_pkg.sv
hdl/pmftl_ram.sv
hdl/pmftl_outq.sv
hdl/page_map_ftl_greedy_gc_top.sv
tb/sv/page_map_ftl_greedy_gc_top_tb.sv
